>>> src/qae_pkg.sv
// ----------------------------------------------------------------------------
// qae_pkg
// Shared types, character codes and helpers for the query argument decoder.
// ----------------------------------------------------------------------------
package qae_pkg;

  localparam int NAME_MAX_DEF = 16;  // default longest argument name
  localparam int NAME_BYTES   = 16;  // bytes held by the two name registers
  localparam int MAX_RESULTS  = 4;   // results one input byte can cause
  localparam int MAX_EMITS    = 3;   // value bytes one input byte can cause
  localparam int CFG_W        = 64;  // widest configuration register
  localparam int LEN_W        = 5;
  localparam int CAP_W        = 16;
  localparam int IN_DATA_W    = 8;
  localparam int OUT_DATA_W   = 16;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    CFG_NAME_LOW  = 2'd0,
    CFG_NAME_HIGH = 2'd1,
    CFG_NAME_LEN  = 2'd2,
    CFG_CAPACITY  = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    MODE_MATCH = 2'd0,
    MODE_SKIP  = 2'd1,
    MODE_VALUE = 2'd2,
    MODE_DONE  = 2'd3
  } seg_mode_t;

  typedef enum logic {
    KIND_VALUE  = 1'b0,
    KIND_STATUS = 1'b1
  } out_kind_t;

  // Query state apart from the name position
  typedef struct packed {
    seg_mode_t        mode;
    logic             found;
    logic [1:0]       pend_cnt;
    logic [7:0]       pend_digit;
    logic [CAP_W-1:0] bytes_written;
  } qstate_t;

  typedef struct packed {
    out_kind_t  kind;
    logic [7:0] value;
    logic       found;
  } result_t;

  // All results of one input transaction
  typedef struct packed {
    logic [2:0]                     count;
    result_t [MAX_RESULTS-1:0]      res;
  } burst_t;

  // {valid, nibble} of a hex digit of either case
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

>>> src/qae_decode.sv
// ----------------------------------------------------------------------------
// qae_decode
// Single-pass step logic: segment matching, percent decoding, capacity limit.
// ----------------------------------------------------------------------------
module qae_decode import qae_pkg::*; #(
  parameter int NAME_MAX = NAME_MAX_DEF,
  parameter int PW       = $clog2(NAME_MAX + 1)
) (
  input  logic [CFG_W-1:0] name_low,
  input  logic [CFG_W-1:0] name_high,
  input  logic [LEN_W-1:0] name_length,
  input  logic [CAP_W-1:0] out_capacity,
  input  logic [PW-1:0]    pos,
  input  qstate_t          st,
  input  logic [7:0]       query_byte,
  input  logic             has_byte,
  input  logic             end_of_query,
  output logic [PW-1:0]    pos_next,
  output qstate_t          st_next,
  output burst_t           burst
);

  logic [7:0]            name_arr [NAME_BYTES];
  logic [PW-1:0]         len;
  logic [MAX_EMITS-1:0]  room;

  always_comb begin
    for (int i = 0; i < NAME_BYTES / 2; i++) begin
      name_arr[i]                  = name_low[8*i +: 8];
      name_arr[i + NAME_BYTES / 2] = name_high[8*i +: 8];
    end
  end

  assign len = (name_length > LEN_W'(NAME_MAX)) ? PW'(NAME_MAX) : PW'(name_length);

  // Room for the i-th value byte of this transaction
  always_comb begin
    for (int i = 0; i < MAX_EMITS; i++) begin
      room[i] = ({1'b0, st.bytes_written} + 17'(i + 1)) < {1'b0, out_capacity};
    end
  end

  always_comb begin
    seg_mode_t  mode;
    logic [PW-1:0] p;
    logic       fnd;
    logic [1:0] pc;
    logic [7:0] pd;
    logic [7:0] cand [MAX_EMITS + 1];
    logic [1:0] cc;
    logic [2:0] n;
    logic [4:0] hc;
    logic [4:0] hp;
    logic [4:0] pos5;
    logic       done;

    mode = st.mode;
    p    = pos;
    fnd  = st.found;
    pc   = st.pend_cnt;
    pd   = st.pend_digit;
    cc   = 2'd0;
    n    = 3'd0;
    done = 1'b0;
    for (int i = 0; i <= MAX_EMITS; i++) begin
      cand[i] = 8'd0;
    end
    hc   = hex_decode(query_byte);
    hp   = hex_decode(st.pend_digit);
    pos5 = 5'(pos);
    burst = '0;

    if (has_byte) begin
      case (mode)
        MODE_MATCH: begin
          if (query_byte == CH_AMP) begin
            p = '0;
          end else if (p < len) begin
            if (query_byte == name_arr[pos5[3:0]]) begin
              p = p + PW'(1);
            end else begin
              mode = MODE_SKIP;
            end
          end else if (query_byte == CH_EQ) begin
            mode = MODE_VALUE;
            fnd  = 1'b1;
          end else begin
            mode = MODE_SKIP;
          end
        end
        MODE_SKIP: begin
          if (query_byte == CH_AMP) begin
            mode = MODE_MATCH;
            p    = '0;
          end
        end
        MODE_VALUE: begin
          if (query_byte == CH_AMP) begin
            if (pc != 2'd0) begin
              cand[cc] = CH_PCT;
              cc = cc + 2'd1;
            end
            if (pc == 2'd2) begin
              cand[cc] = pd;
              cc = cc + 2'd1;
            end
            pc   = 2'd0;
            mode = MODE_DONE;
          end else begin
            if (pc == 2'd1 && hc[4]) begin
              pd   = query_byte;
              pc   = 2'd2;
              done = 1'b1;
            end else if (pc == 2'd2 && hc[4]) begin
              cand[cc] = {hp[3:0], hc[3:0]};
              cc   = cc + 2'd1;
              pc   = 2'd0;
              done = 1'b1;
            end else if (pc != 2'd0) begin
              // Stray percent: flush what was held as written
              cand[cc] = CH_PCT;
              cc = cc + 2'd1;
              if (pc == 2'd2) begin
                cand[cc] = pd;
                cc = cc + 2'd1;
              end
              pc = 2'd0;
            end
            if (!done) begin
              if (query_byte == CH_PLUS) begin
                cand[cc] = CH_SPACE;
                cc = cc + 2'd1;
              end else if (query_byte == CH_PCT) begin
                pc = 2'd1;
              end else begin
                cand[cc] = query_byte;
                cc = cc + 2'd1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (end_of_query && mode == MODE_VALUE) begin
      if (pc != 2'd0) begin
        cand[cc] = CH_PCT;
        cc = cc + 2'd1;
      end
      if (pc == 2'd2) begin
        cand[cc] = pd;
        cc = cc + 2'd1;
      end
      pc = 2'd0;
    end

    // Capacity check: room is monotone, so kept bytes form a prefix
    for (int i = 0; i < MAX_EMITS; i++) begin
      if (2'(i) < cc && room[i]) begin
        burst.res[n[1:0]] = '{kind: KIND_VALUE, value: cand[i], found: 1'b0};
        n = n + 3'd1;
      end
    end

    st_next.bytes_written = st.bytes_written + CAP_W'(n);

    if (end_of_query) begin
      burst.res[n[1:0]] = '{kind: KIND_STATUS, value: 8'd0,
                            found: fnd && (out_capacity != '0)};
      n    = n + 3'd1;
      mode = MODE_MATCH;
      p    = '0;
      fnd  = 1'b0;
      pc   = 2'd0;
      pd   = 8'd0;
      st_next.bytes_written = '0;
    end

    burst.count        = n;
    pos_next           = p;
    st_next.mode       = mode;
    st_next.found      = fnd;
    st_next.pend_cnt   = pc;
    st_next.pend_digit = pd;
  end

endmodule

>>> src/qae_burst.sv
// ----------------------------------------------------------------------------
// qae_burst
// Result buffer: holds the results of one transaction and sends them in order.
// ----------------------------------------------------------------------------
module qae_burst import qae_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  burst_t                burst_in,
  output logic                  can_load,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [7:0] value_byte, [8] found
  output logic                  m_axis_tuser,  // out_kind
  output logic                  m_axis_tlast
);

  result_t [MAX_RESULTS-1:0] res;
  logic [1:0]                rd;
  logic [2:0]                remain;
  logic                      fire;
  result_t                   cur;

  assign fire     = m_axis_tvalid && m_axis_tready;
  assign can_load = (remain == 3'd0) || (remain == 3'd1 && m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= 3'd0;
      rd     <= 2'd0;
    end else if (load && burst_in.count != 3'd0) begin
      remain <= burst_in.count;
      rd     <= 2'd0;
    end else if (fire) begin
      remain <= remain - 3'd1;
      rd     <= rd + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && burst_in.count != 3'd0) begin
      res <= burst_in.res;
    end
  end

  assign cur           = res[rd];
  assign m_axis_tvalid = remain != 3'd0;
  assign m_axis_tlast  = remain == 3'd1;
  assign m_axis_tuser  = cur.kind;
  assign m_axis_tdata  = {{(OUT_DATA_W - 9){1'b0}}, cur.found, cur.value};

endmodule

>>> src/query_arg_extract_decode_top.sv
// ----------------------------------------------------------------------------
// query_arg_extract_decode_top
// URL query argument extractor with form decoding of the matched value.
// ----------------------------------------------------------------------------
// Usage:
//   Program name bytes, name length and output capacity over the cfg port
//   while no query is in flight. Feed the query on the s_axis channel, one
//   character per transaction: tdata is the character, tuser flags that the
//   character is present (clear it for an empty query), tlast closes the
//   query. Decoded value bytes and one final status leave on m_axis; tuser
//   tells a value byte (0) from the status (1), tdata[8] is found, and tlast
//   marks the last result caused by each input transaction.
//   Results of a transaction appear in the cycle after it is accepted.
//   One character per cycle while each causes at most one result and
//   m_axis is ready; a character causing more results holds s_axis while
//   the result buffer drains them on m_axis, one result per ready cycle.
//   Reset clears configuration and query state and empties the buffer.
//   When m_axis stalls, hold the buffered results; s_axis is taken again
//   once the last buffered result is being taken.
// ----------------------------------------------------------------------------
module query_arg_extract_decode_top import qae_pkg::*; #(
  parameter int NAME_MAX = NAME_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] query_byte
  input  logic                  s_axis_tuser,  // has_byte
  input  logic                  s_axis_tlast,  // end_of_query
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [7:0] value_byte, [8] found
  output logic                  m_axis_tuser,  // out_kind
  output logic                  m_axis_tlast
);

  localparam int PW = $clog2(NAME_MAX + 1);

  // Configuration registers
  logic [CFG_W-1:0] name_low;
  logic [CFG_W-1:0] name_high;
  logic [LEN_W-1:0] name_length;
  logic [CAP_W-1:0] out_capacity;

  // Query state
  logic [PW-1:0] pos;
  logic [PW-1:0] pos_next;
  qstate_t       st;
  qstate_t       st_next;

  burst_t burst;
  logic   accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      name_low     <= '0;
      name_high    <= '0;
      name_length  <= '0;
      out_capacity <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_NAME_LOW:  name_low     <= cfg_wdata;
        CFG_NAME_HIGH: name_high    <= cfg_wdata;
        CFG_NAME_LEN:  name_length  <= cfg_wdata[LEN_W-1:0];
        CFG_CAPACITY:  out_capacity <= cfg_wdata[CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Advance the query state on every accepted character
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      st  <= '{mode: MODE_MATCH, found: 1'b0, pend_cnt: 2'd0,
               pend_digit: 8'd0, bytes_written: '0};
    end else if (accept) begin
      pos <= pos_next;
      st  <= st_next;
    end
  end

  qae_decode #(
    .NAME_MAX (NAME_MAX),
    .PW       (PW)
  ) u_decode (
    .name_low     (name_low),
    .name_high    (name_high),
    .name_length  (name_length),
    .out_capacity (out_capacity),
    .pos          (pos),
    .st           (st),
    .query_byte   (s_axis_tdata[7:0]),
    .has_byte     (s_axis_tuser),
    .end_of_query (s_axis_tlast),
    .pos_next     (pos_next),
    .st_next      (st_next),
    .burst        (burst)
  );

  qae_burst u_burst (
    .clk           (clk),
    .rst           (rst),
    .load          (accept),
    .burst_in      (burst),
    .can_load      (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
